### rtl/wltp_pkg.sv
`timescale 1ns / 1ps
package wltp_pkg;

  // Fixed field widths.
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned SPACE_W    = 16;
  localparam int unsigned LEAD_W     = 17;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned STEP_W     = 8;

  // Fit arithmetic widths, bounded by a count of at most 127.
  localparam int unsigned T_W   = 13;  // n(n+1)/2
  localparam int unsigned K6_W  = 19;  // n(n^2-1)/6
  localparam int unsigned KK_W  = 35;  // spacing * K6
  localparam int unsigned M_W   = 25;  // spacing*(n-1) + 2*lead, signed
  localparam int unsigned DEN_W = 42;  // KK * n

  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_DISTANCE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INSERT, ST_WALK, ST_PREP1, ST_PREP2, ST_MUL_A, ST_PREP3,
    ST_MUL_B, ST_DIV_SETUP, ST_DIV, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INSERT, OP_WALK, OP_PREP1, OP_PREP2, OP_PREP3,
    OP_MUL, OP_DIV_SETUP, OP_DIV, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic short_win;
    logic walk_last;
    logic mul_last;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/wltp_ctrl.sv
`timescale 1ns / 1ps
module wltp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  wltp_pkg::stat_t stat,
  output wltp_pkg::cmd_t  cmd
);
  import wltp_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step + 1'b1;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        step_next = '0;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.op     = OP_INSERT;
        state_next = ST_WALK;
        step_next  = '0;
      end
      ST_WALK: begin
        if (stat.short_win) begin
          state_next = ST_FINISH;
          step_next  = '0;
        end else begin
          cmd.op = OP_WALK;
          if (stat.walk_last) begin
            state_next = ST_PREP1;
            step_next  = '0;
          end
        end
      end
      ST_PREP1: begin
        cmd.op     = OP_PREP1;
        state_next = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.op     = OP_PREP2;
        state_next = ST_MUL_A;
        step_next  = '0;
      end
      ST_MUL_A: begin
        cmd.op = OP_MUL;
        if (stat.mul_last) begin
          state_next = ST_PREP3;
          step_next  = '0;
        end
      end
      ST_PREP3: begin
        cmd.op     = OP_PREP3;
        state_next = ST_MUL_B;
        step_next  = '0;
      end
      ST_MUL_B: begin
        cmd.op = OP_MUL;
        if (stat.mul_last) begin
          state_next = ST_DIV_SETUP;
          step_next  = '0;
        end
      end
      ST_DIV_SETUP: begin
        cmd.op     = OP_DIV_SETUP;
        state_next = ST_DIV;
        step_next  = '0;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) begin
          state_next = ST_FINISH;
          step_next  = '0;
        end
      end
      ST_FINISH: begin
        step_next = '0;
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

endmodule

### rtl/wltp_dp.sv
`timescale 1ns / 1ps
module wltp_dp #(
  parameter int unsigned WINDOW_MAX  = wltp_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = wltp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wltp_pkg::cmd_t                      cmd,
  output wltp_pkg::stat_t                     stat,
  input  logic                                cfg_valid,
  input  logic [wltp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wltp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [wltp_pkg::IN_W-1:0]    sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wltp_pkg::OUT_W-1:0]   predicted,
  output logic                                status,
  output logic                                clipped,
  output logic [wltp_pkg::CNT_W-1:0]          held_count
);
  import wltp_pkg::*;

  localparam int unsigned AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SW     = ((AW > CNT_W) ? AW : CNT_W) + 2;
  localparam int unsigned SY_W   = SAMPLE_BITS + 7;
  localparam int unsigned SKY_W  = SAMPLE_BITS + 14;
  localparam int unsigned NU_W   = SAMPLE_BITS + 22;
  localparam int unsigned NUM_W  = SAMPLE_BITS + 48;

  // Configuration registers.
  logic [CNT_W-1:0]          window_len;
  logic [SPACE_W-1:0]        sample_spacing;
  logic signed [LEAD_W-1:0]  lead_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= CNT_W'(64);
      sample_spacing <= SPACE_W'(1);
      lead_distance  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEN:     window_len     <= cfg_data[CNT_W-1:0];
        REG_SAMPLE_SPACING: sample_spacing <= cfg_data[SPACE_W-1:0];
        REG_LEAD_DISTANCE:  lead_distance  <= $signed(cfg_data[LEAD_W-1:0]);
        default: ;
      endcase
    end
  end

  // Window memory and its pointers.
  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] smp;
  logic [AW-1:0]          oldest;
  logic [AW-1:0]          rd_ptr;
  logic [CNT_W-1:0]       count;

  logic [SW-1:0] cap_w, cnt_w, cnt_adj, osum, wsum;
  logic [AW-1:0] wr_addr;

  always_comb begin
    cap_w = (window_len == '0) ? SW'(1) : SW'(window_len);
    if (cap_w > SW'(WINDOW_MAX)) begin
      cap_w = SW'(WINDOW_MAX);
    end
    cnt_w   = SW'(count);
    osum    = SW'(oldest);
    cnt_adj = cnt_w;
    if (cnt_w >= cap_w) begin
      osum    = SW'(oldest) + (cnt_w - cap_w + SW'(1));
      cnt_adj = cap_w - SW'(1);
    end
    if (osum >= SW'(WINDOW_MAX)) begin
      osum = osum - SW'(WINDOW_MAX);
    end
    wsum = osum + cnt_adj;
    if (wsum >= SW'(WINDOW_MAX)) begin
      wsum = wsum - SW'(WINDOW_MAX);
    end
    wr_addr = wsum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_INSERT) begin
      mem[wr_addr] <= smp;
    end
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      rd_ptr <= '0;
    end else if (cmd.op == OP_INSERT) begin
      oldest <= osum[AW-1:0];
      count  <= CNT_W'(cnt_adj + SW'(1));
      rd_ptr <= osum[AW-1:0];
    end else if (cmd.op == OP_WALK) begin
      rd_ptr <= (rd_ptr == AW'(WINDOW_MAX - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  // Fit arithmetic.
  logic signed [SY_W-1:0]   sy;
  logic signed [SKY_W-1:0]  sky;
  logic [T_W-1:0]           tsum, c2;
  logic [K6_W-1:0]          k6;
  logic signed [NU_W-1:0]   prod_a, prod_b, nu;
  logic [KK_W-1:0]          kk, mul_b;
  logic [M_W-2:0]           sm;
  logic signed [M_W-1:0]    mm;
  logic [DEN_W-1:0]         den, rem;
  logic signed [NUM_W-1:0]  num, mul_a;
  logic [NUM_W-1:0]         quo;
  logic                     neg;

  logic [CNT_W-1:0]         kidx;
  logic signed [SY_W-1:0]   v;
  logic [T_W-1:0]           c2_new;
  logic [SPACE_W-1:0]       sp;
  logic [DEN_W:0]           rem_sh;
  logic                     ge;

  assign kidx   = cmd.step[CNT_W-1:0];
  assign v      = SY_W'($signed(rd_data));
  assign c2_new = c2 + T_W'(kidx - 1'b1);
  assign sp     = (sample_spacing == '0) ? SPACE_W'(1) : sample_spacing;
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        smp <= sample[SAMPLE_BITS-1:0];
      end
      OP_INSERT: begin
        sy   <= '0;
        sky  <= '0;
        tsum <= '0;
        c2   <= '0;
        k6   <= '0;
      end
      OP_WALK: begin
        // The read data of step i belongs to the i-th oldest sample.
        if (cmd.step != '0) begin
          sy   <= sy + v;
          sky  <= sky + SKY_W'($signed({1'b0, kidx}) * v);
          tsum <= tsum + T_W'(kidx);
          c2   <= c2_new;
          k6   <= k6 + K6_W'(c2_new);
        end
      end
      OP_PREP1: begin
        prod_a <= NU_W'($signed({1'b0, count}) * sky);
        prod_b <= NU_W'($signed({1'b0, tsum}) * sy);
        kk     <= KK_W'(sp * k6);
        sm     <= (M_W-1)'(sp * (count - 1'b1));
      end
      OP_PREP2: begin
        nu    <= prod_a - prod_b;
        den   <= DEN_W'(kk * count);
        mm    <= $signed({1'b0, sm}) + M_W'(lead_distance <<< 1);
        mul_a <= NUM_W'(sy);
        mul_b <= kk;
        num   <= '0;
      end
      OP_PREP3: begin
        mul_a <= mm[M_W-1] ? -NUM_W'(nu) : NUM_W'(nu);
        mul_b <= mm[M_W-1] ? KK_W'(-mm) : KK_W'(mm);
      end
      OP_MUL: begin
        if (mul_b[0]) begin
          num <= num + mul_a;
        end
        mul_a <= mul_a <<< 1;
        mul_b <= mul_b >> 1;
      end
      OP_DIV_SETUP: begin
        neg <= num[NUM_W-1];
        quo <= (num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num)) + NUM_W'(den >> 1);
        rem <= '0;
      end
      OP_DIV: begin
        rem <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
      end
      default: ;
    endcase
  end

  // Rounding, saturation and the output register.
  logic [NUM_W-1:0] lim;
  logic             over;
  logic [OUT_W-1:0] mag;

  assign lim  = neg ? NUM_W'(33'h080000000) : NUM_W'(33'h07FFFFFFF);
  assign over = quo > lim;
  assign mag  = over ? lim[OUT_W-1:0] : quo[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      held_count <= count;
      if (count < CNT_W'(2)) begin
        predicted <= '0;
        status    <= 1'b1;
        clipped   <= 1'b0;
      end else begin
        predicted <= neg ? $signed(-mag) : $signed(mag);
        status    <= 1'b0;
        clipped   <= over;
      end
    end
  end

  assign stat.short_win = count < CNT_W'(2);
  assign stat.walk_last = cmd.step == STEP_W'(count);
  assign stat.mul_last  = cmd.step == STEP_W'(KK_W - 1);
  assign stat.div_last  = cmd.step == STEP_W'(NUM_W - 1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### rtl/window_linear_trend_predictor.sv
`timescale 1ns / 1ps
// Windowed least-squares trend predictor. Each input item is one signed
// Q16.16 sample that joins a sliding window of up to window_len samples; the
// block fits an exact integer least-squares line over the held samples and
// returns one result item with the line extrapolated lead_distance past the
// newest sample, rounded to nearest and saturated to 32 bits. One item is
// worked at a time: an accepted item walks the window memory through its
// single read port, two 35-step shift-add multiplies build the wide
// numerator and an 80-step restoring divider forms the quotient; while
// fewer than two samples are held, the fit is skipped. The result waits in
// an output register, so the next item can be accepted before the previous
// result is taken. Configuration writes are always accepted and are meant
// to land only while the block is idle.
module window_linear_trend_predictor #(
  parameter int unsigned WINDOW_MAX  = wltp_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = wltp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wltp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wltp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [wltp_pkg::IN_W-1:0]  sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wltp_pkg::OUT_W-1:0] predicted,
  output logic                              status,
  output logic                              clipped,
  output logic [wltp_pkg::CNT_W-1:0]        held_count
);
  import wltp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  wltp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wltp_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .predicted  (predicted),
    .status     (status),
    .clipped    (clipped),
    .held_count (held_count)
  );

  // A short window always reports a zero, unclipped prediction.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> predicted == '0 && !clipped)
    else $error("short window result is not zero");

  // The held count of a result lies within the window capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_count != '0 && 32'(held_count) <= WINDOW_MAX)
    else $error("held count out of range");

  // A clipped result sits on one of the two saturation limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> predicted == 32'sh7FFFFFFF ||
                             predicted == 32'sh80000000)
    else $error("clipped result is not at a limit");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

endmodule
